>>> rtl/core/gpev_pkg.sv
// Shared types and constants for the gamepad event generator core.
`timescale 1ns / 1ps
package gpev_pkg;

  localparam int NUM_BUTTONS = 14;
  localparam int NUM_AXES    = 6;
  localparam int NUM_STICKS  = 4;
  localparam int NUM_POS     = NUM_BUTTONS + NUM_AXES;
  localparam int POS_W       = $clog2(NUM_POS);
  localparam int AXIS_W      = $clog2(NUM_AXES);

  localparam int BTN_W   = 14;
  localparam int TRIG_W  = 15;
  localparam int AXV_W   = 16;
  localparam int DZ_W    = 15;
  localparam int IDX_W   = 4;
  localparam int KIND_W  = 2;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 24;

  localparam int DIV_STEPS = 16;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [DZ_W-1:0] DZ_LEFT_RESET  = 15'd7849;
  localparam logic [DZ_W-1:0] DZ_RIGHT_RESET = 15'd8689;

  localparam logic CFG_LEFT_DZ  = 1'b0;
  localparam logic CFG_RIGHT_DZ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_AXIS    = 2'd2;

  localparam logic [AXV_W-1:0] VAL_PRESS   = 16'h7FFF;
  localparam logic [AXV_W-1:0] VAL_RELEASE = 16'h0000;
  localparam logic [AXV_W-1:0] VAL_POS_MAX = 16'h7FFF;
  localparam logic [AXV_W-1:0] VAL_NEG_MAG = 16'h8000;

  typedef struct packed {
    logic             done;
    logic [AXV_W-1:0] value;
  } lane_res_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0]           now;
    logic [TRIG_W-1:0]                lt;
    logic [TRIG_W-1:0]                rt;
    logic [NUM_STICKS-1:0][AXV_W-1:0] stick;
  } load_t;

endpackage

>>> rtl/core/gpev_lane.sv
// Stick deadzone rescale lane with a restoring divider, one quotient bit a cycle.
`timescale 1ns / 1ps
module gpev_lane
  import gpev_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AXV_W-1:0] value,
  input  logic [DZ_W-1:0]         deadzone,
  output lane_res_t               res
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic              neg;
  logic              zero;
  logic              sat;
  logic [AXV_W-1:0]  rem;
  logic [AXV_W-1:0]  num;
  logic [AXV_W-1:0]  div;
  logic [AXV_W-1:0]  quo;

  logic [AXV_W-1:0]  mag_in;
  logic [AXV_W-1:0]  x_in;
  logic [AXV_W-1:0]  d_in;
  logic              zero_in;
  logic              sat_in;
  logic [AXV_W:0]    trial;
  logic              fits;
  logic [AXV_W-1:0]  mag_out;

  always_comb begin
    mag_in  = value[AXV_W-1] ? AXV_W'(-value) : value;
    zero_in = mag_in <= {1'b0, deadzone};
    x_in    = mag_in - {1'b0, deadzone};
    d_in    = VAL_NEG_MAG - {1'b0, deadzone};
    sat_in  = {1'b0, x_in} >= {d_in, 1'b0};
    trial   = {rem, num[AXV_W-1]};
    fits    = trial >= {1'b0, div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == STEP_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= value[AXV_W-1];
      zero <= zero_in;
      sat  <= sat_in;
      rem  <= {1'b0, x_in[AXV_W-1:1]};
      num  <= {x_in[0], {(AXV_W-1){1'b0}}};
      div  <= d_in;
      quo  <= '0;
    end else if (busy) begin
      num <= {num[AXV_W-2:0], 1'b0};
      quo <= {quo[AXV_W-2:0], fits};
      rem <= fits ? AXV_W'(trial - {1'b0, div}) : trial[AXV_W-1:0];
    end
  end

  always_comb begin
    if (neg) begin
      mag_out = (sat || quo > VAL_NEG_MAG) ? VAL_NEG_MAG : quo;
    end else begin
      mag_out = (sat || quo[AXV_W-1]) ? VAL_POS_MAX : quo;
    end
    res.done  = done;
    if (zero) begin
      res.value = '0;
    end else if (neg) begin
      res.value = AXV_W'(-mag_out);
    end else begin
      res.value = mag_out;
    end
  end

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("lane done while busy");
  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    (busy && !start && cnt == STEP_W'(DIV_STEPS - 1)) |=> done)
    else $error("lane finished without done");
`endif

endmodule

>>> rtl/core/gpev_merge.sv
// Event merge: held state, change detection and serialization into output beats.
`timescale 1ns / 1ps
module gpev_merge
  import gpev_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  load_t                 ld,
  output logic                  busy,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // source_index, event_value, zero pad
  output logic [KIND_W-1:0]     m_tuser,   // event_kind
  output logic                  m_tlast
);

  logic [NUM_BUTTONS-1:0] held;
  logic [AXV_W-1:0]       axis_store [NUM_AXES];
  logic [NUM_POS-1:0]     mask;
  logic [KIND_W-1:0]      out_kind;
  logic [IDX_W-1:0]       out_idx;
  logic [AXV_W-1:0]       out_val;
  logic                   out_last;

  logic [AXV_W-1:0]       nv [NUM_AXES];
  logic [NUM_AXES-1:0]    ax_hit;
  logic [POS_W-1:0]       sel;
  logic [NUM_POS-1:0]     sel_bit;
  logic [AXIS_W-1:0]      ax_sel;
  logic                   sel_btn;
  logic                   advance;

  always_comb begin
    nv[0] = {1'b0, ld.lt};
    nv[1] = {1'b0, ld.rt};
    for (int j = 0; j < NUM_STICKS; j++) begin
      nv[j + 2] = ld.stick[j];
    end
    for (int j = 0; j < NUM_AXES; j++) begin
      ax_hit[j] = (nv[j] != '0) || (axis_store[j] != '0);
    end
  end

  always_comb begin
    sel = '0;
    for (int i = NUM_POS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = POS_W'(i);
      end
    end
    sel_bit = NUM_POS'(1) << sel;
    sel_btn = sel < POS_W'(NUM_BUTTONS);
    ax_sel  = AXIS_W'(sel - POS_W'(NUM_BUTTONS));
    advance = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      mask <= '0;
      for (int j = 0; j < NUM_AXES; j++) begin
        axis_store[j] <= '0;
      end
    end else if (load) begin
      held <= ld.now;
      mask <= {ax_hit, ld.now ^ held};
      for (int j = 0; j < NUM_AXES; j++) begin
        axis_store[j] <= nv[j];
      end
    end else if (advance && mask != '0) begin
      mask <= mask & ~sel_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= mask != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mask != '0) begin
      out_last <= (mask & ~sel_bit) == '0;
      if (sel_btn) begin
        out_idx  <= IDX_W'(sel);
        out_kind <= held[sel[IDX_W-1:0]] ? KIND_PRESS : KIND_RELEASE;
        out_val  <= held[sel[IDX_W-1:0]] ? VAL_PRESS : VAL_RELEASE;
      end else begin
        out_idx  <= IDX_W'(ax_sel);
        out_kind <= KIND_AXIS;
        out_val  <= axis_store[ax_sel];
      end
    end
  end

  assign busy    = (mask != '0) || m_tvalid;
  assign m_tdata = {4'b0, out_val, out_idx};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

`ifndef SYNTH
  a_load_idle: assert property (@(posedge clk) disable iff (rst) load |-> !busy)
    else $error("load while events pending");
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> mask == '0)
    else $error("last beat with events pending");
`endif

endmodule

>>> rtl/core/gamepad_event_generator_core.sv
// Top level of the gamepad event generator: control, config, stick lanes and merge.
// Four stick lanes rescale in parallel, one quotient bit a cycle.
// The merge then sends up to 20 event beats per item, one a cycle unless m_tready is low.
// The next input item is accepted only after all events of the last one have drained.
// Synchronous reset clears held buttons and axes and loads default deadzones.
`timescale 1ns / 1ps
module gamepad_event_generator_core
  import gpev_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // buttons, left_trigger, right_trigger,
                                           // left_x, left_y, right_x, right_y, zero pad
  input  logic                  s_tuser,   // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // source_index, event_value, zero pad
  output logic [KIND_W-1:0]     m_tuser,   // event_kind
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [DZ_W-1:0]       cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state;
  logic [DZ_W-1:0]        left_dz;
  logic [DZ_W-1:0]        right_dz;
  logic [NUM_BUTTONS-1:0] now_r;
  logic [TRIG_W-1:0]      lt_r;
  logic [TRIG_W-1:0]      rt_r;

  logic                   accept;
  logic                   is_reset;
  logic [AXV_W-1:0]       stick_in [NUM_STICKS];
  lane_res_t              lane_res [NUM_STICKS];
  logic                   lanes_done;
  logic                   load;
  load_t                  ld;
  logic                   merge_busy;

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign is_reset = s_tuser;

  always_comb begin
    stick_in[0] = is_reset ? '0 : s_tdata[59:44];
    stick_in[1] = is_reset ? '0 : s_tdata[75:60];
    stick_in[2] = is_reset ? '0 : s_tdata[91:76];
    stick_in[3] = is_reset ? '0 : s_tdata[107:92];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= DZ_LEFT_RESET;
      right_dz <= DZ_RIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_DZ:  left_dz  <= cfg_data;
        CFG_RIGHT_DZ: right_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= is_reset ? '0 : s_tdata[NUM_BUTTONS-1:0];
      lt_r  <= is_reset ? '0 : s_tdata[28:14];
      rt_r  <= is_reset ? '0 : s_tdata[43:29];
    end
  end

  for (genvar g = 0; g < NUM_STICKS; g++) begin : g_lane
    gpev_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .start    (accept),
      .value    (stick_in[g]),
      .deadzone (g < NUM_STICKS / 2 ? left_dz : right_dz),
      .res      (lane_res[g])
    );
  end

  always_comb begin
    lanes_done = 1'b1;
    for (int j = 0; j < NUM_STICKS; j++) begin
      lanes_done = lanes_done && lane_res[j].done;
      ld.stick[j] = lane_res[j].value;
    end
    ld.now = now_r;
    ld.lt  = lt_r;
    ld.rt  = rt_r;
    load   = (state == ST_CALC) && lanes_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_CALC;
        end
        ST_CALC: begin
          if (lanes_done) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!merge_busy) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  gpev_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .ld       (ld),
    .busy     (merge_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !merge_busy)
    else $error("idle with events pending");
`endif

endmodule

>>> dv/gamepad_event_generator_core_checker.sv
// Checker for the gamepad event generator: predicts event beats and compares them.
`timescale 1ns / 1ps
module gamepad_event_generator_core_checker
  import gpev_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [KIND_W-1:0]     m_tuser,
  input  logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [DZ_W-1:0]       cfg_data,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [AXV_W-1:0]  value;
    logic              last;
  } gp_event_t;

  gp_event_t              pending_events[$];
  logic [NUM_BUTTONS-1:0] held_mask;
  logic [AXV_W-1:0]       axis_level [NUM_AXES];
  logic [DZ_W-1:0]        left_dz;
  logic [DZ_W-1:0]        right_dz;
  int                     errors;
  int                     beat_count;

  initial begin
    errors     = 0;
    beat_count = 0;
  end

  function automatic logic [AXV_W-1:0] stick_scaled(input logic [AXV_W-1:0] raw,
                                                    input logic [DZ_W-1:0] dz);
    int mag;
    int m;
    mag = raw[AXV_W-1] ? 65536 - int'(raw) : int'(raw);
    if (mag <= int'(dz)) return '0;
    m = ((mag - int'(dz)) * 32768) / (32768 - int'(dz));
    if (raw[AXV_W-1]) begin
      if (m > 32768) m = 32768;
      return AXV_W'(-m);
    end
    if (m > 32767) m = 32767;
    return AXV_W'(m);
  endfunction

  function automatic gp_event_t make_event(input logic [KIND_W-1:0] kind, input int idx,
                                           input logic [AXV_W-1:0] value);
    gp_event_t ev;
    ev.kind  = kind;
    ev.idx   = IDX_W'(idx);
    ev.value = value;
    ev.last  = 1'b0;
    return ev;
  endfunction

  task automatic predict_events(input logic mode, input logic [IN_DATA_W-1:0] data);
    gp_event_t              burst[$];
    gp_event_t              ev;
    logic [NUM_BUTTONS-1:0] now;
    logic [AXV_W-1:0]       fresh [NUM_AXES];
    if (mode) begin
      for (int i = 0; i < NUM_BUTTONS; i++)
        if (held_mask[i]) burst.push_back(make_event(KIND_RELEASE, i, VAL_RELEASE));
      for (int i = 0; i < NUM_AXES; i++) begin
        if (axis_level[i] != '0) burst.push_back(make_event(KIND_AXIS, i, '0));
        axis_level[i] = '0;
      end
      held_mask = '0;
    end else begin
      now = data[13:0];
      for (int i = 0; i < NUM_BUTTONS; i++)
        if (now[i] != held_mask[i])
          burst.push_back(now[i] ? make_event(KIND_PRESS, i, VAL_PRESS)
                                 : make_event(KIND_RELEASE, i, VAL_RELEASE));
      held_mask = now;
      fresh[0] = {1'b0, data[28:14]};
      fresh[1] = {1'b0, data[43:29]};
      fresh[2] = stick_scaled(data[59:44], left_dz);
      fresh[3] = stick_scaled(data[75:60], left_dz);
      fresh[4] = stick_scaled(data[91:76], right_dz);
      fresh[5] = stick_scaled(data[107:92], right_dz);
      for (int i = 0; i < NUM_AXES; i++) begin
        if (fresh[i] != '0 || axis_level[i] != '0)
          burst.push_back(make_event(KIND_AXIS, i, fresh[i]));
        axis_level[i] = fresh[i];
      end
    end
    foreach (burst[i]) begin
      ev      = burst[i];
      ev.last = (i == burst.size() - 1);
      pending_events.push_back(ev);
    end
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("checker: beat %0d %s: got 0x%0h expected 0x%0h", beat_count, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    gp_event_t want;
    if (rst) begin
      held_mask = '0;
      for (int i = 0; i < NUM_AXES; i++) axis_level[i] = '0;
      left_dz  = DZ_LEFT_RESET;
      right_dz = DZ_RIGHT_RESET;
      pending_events.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LEFT_DZ) left_dz = cfg_data;
        else right_dz = cfg_data;
      end
      if (s_tvalid && s_tready) predict_events(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_events.size() == 0) begin
          flag_mismatch("beat with no event pending", m_tdata, 0);
        end else begin
          want = pending_events.pop_front();
          if (m_tuser !== want.kind) flag_mismatch("event_kind", m_tuser, want.kind);
          if (m_tdata[3:0] !== want.idx) flag_mismatch("source_index", m_tdata[3:0], want.idx);
          if (m_tdata[19:4] !== want.value)
            flag_mismatch("event_value", m_tdata[19:4], want.value);
          if (m_tlast !== want.last) flag_mismatch("last", m_tlast, want.last);
        end
        beat_count++;
      end
    end
    fail_count    <= errors;
    pending_count <= pending_events.size();
  end

endmodule

>>> dv/gamepad_event_generator_core_tb.sv
// Testbench top for the gamepad event generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module gamepad_event_generator_core_tb;
  import gpev_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 12;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int BURST_ITEMS     = 12;
  localparam int LONG_HOLD       = 400;
  localparam int SETTLE_CYCLES   = 48;
  localparam int CYCLE_LIMIT     = 1000000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [DZ_W-1:0]       cfg_data;

  int                     fail_count;
  int                     pending_count;
  int                     cycles;
  bit                     tx_idle;
  bit                     rx_idle;
  int                     rx_long_hold;
  logic [NUM_BUTTONS-1:0] last_buttons;
  logic [DZ_W-1:0]        left_dz;
  logic [DZ_W-1:0]        right_dz;

  gamepad_event_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gamepad_event_generator_core_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("gamepad_event_generator_core_tb: FAIL");
      $finish;
    end
  end

  task automatic offer(input logic mode, input logic [NUM_BUTTONS-1:0] btn,
                       input logic [TRIG_W-1:0] lt, input logic [TRIG_W-1:0] rt,
                       input logic [AXV_W-1:0] lx, input logic [AXV_W-1:0] ly,
                       input logic [AXV_W-1:0] rx, input logic [AXV_W-1:0] ry);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, ry, rx, ly, lx, rt, lt, btn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_buttons = mode ? '0 : btn;
  endtask

  function automatic logic [TRIG_W-1:0] rand_trigger();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return TRIG_W'($urandom);
    endcase
  endfunction

  function automatic logic [AXV_W-1:0] rand_stick(input logic [DZ_W-1:0] dz);
    int mag;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: begin
        mag = int'(dz) + int'($urandom_range(0, 4)) - 2;
        if (mag < 0) mag = 0;
        return $urandom_range(0, 1) ? AXV_W'(-mag) : AXV_W'(mag);
      end
      4: begin
        mag = int'($urandom_range(0, dz));
        return $urandom_range(0, 1) ? AXV_W'(-mag) : AXV_W'(mag);
      end
      default: return AXV_W'($urandom);
    endcase
  endfunction

  task automatic offer_random();
    int                     pick;
    logic [NUM_BUTTONS-1:0] btn;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      offer(1'b1, NUM_BUTTONS'($urandom), TRIG_W'($urandom), TRIG_W'($urandom),
            AXV_W'($urandom), AXV_W'($urandom), AXV_W'($urandom), AXV_W'($urandom));
    end else if (pick == 1) begin
      offer(1'b0, '0, '0, '0, '0, '0, '0, '0);
    end else begin
      case ($urandom_range(0, 4))
        0: btn = last_buttons ^ (NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1));
        1: btn = NUM_BUTTONS'($urandom);
        2: btn = last_buttons;
        3: btn = $urandom_range(0, 1) ? '1 : '0;
        default: btn = last_buttons ^ (NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1))
                                    ^ (NUM_BUTTONS'(1) << $urandom_range(0, NUM_BUTTONS - 1));
      endcase
      offer(1'b0, btn, rand_trigger(), rand_trigger(), rand_stick(left_dz),
            rand_stick(left_dz), rand_stick(right_dz), rand_stick(right_dz));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_deadzones(input logic [DZ_W-1:0] l, input logic [DZ_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LEFT_DZ;
    cfg_data  <= l;
    @(posedge clk);
    cfg_index <= CFG_RIGHT_DZ;
    cfg_data  <= r;
    @(posedge clk);
    cfg_we   <= 1'b0;
    left_dz  = l;
    right_dz = r;
  endtask

  initial begin : receiver
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_long_hold > 0) begin
        stall        = rx_long_hold;
        rx_long_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_LEFT_DZ;
    cfg_data     = '0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    rx_long_hold = 0;
    last_buttons = '0;
    left_dz      = DZ_LEFT_RESET;
    right_dz     = DZ_RIGHT_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(1'b1, '1, '1, '1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
    offer(1'b0, '0, '0, '0, '0, '0, '0, '0);
    offer(1'b0, '1, '1, '1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    offer(1'b0, '1, '1, '1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    offer(1'b0, '0, '0, '0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    offer(1'b0, 14'h2AAA, 15'd1, 15'd1, 16'd7849, -16'sd7849, 16'd8689, -16'sd8689);
    offer(1'b0, 14'h1555, '0, '1, 16'd7850, -16'sd7850, 16'd8690, -16'sd8690);
    offer(1'b0, 14'h1555, '0, '0, 16'd100, -16'sd100, 16'h0001, 16'hFFFF);
    offer(1'b0, 14'h1555, '0, '0, '0, '0, '0, '0);
    offer(1'b0, 14'h1555, 15'd12345, '0, 16'h4000, 16'hC000, 16'h7FFE, 16'h8001);
    offer(1'b1, '0, '0, '0, '0, '0, '0, '0);
    offer(1'b1, 14'h3FFF, '1, '1, '1, '1, '1, '1);
    offer(1'b0, 14'h0001, '0, '0, 16'd20000, -16'sd20000, '0, '0);
    offer(1'b0, 14'h2000, '0, '0, '0, '0, 16'd30000, -16'sd30000);
    offer(1'b0, '0, '0, '0, '0, '0, '0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: set_deadzones('0, '1);
          2: set_deadzones('1, '0);
          3: set_deadzones(DZ_W'($urandom), DZ_W'($urandom));
          4: set_deadzones(DZ_W'(1), DZ_W'(32766));
          default: set_deadzones(DZ_LEFT_RESET, DZ_RIGHT_RESET);
        endcase
      end
      tx_idle = (p != 4);
      rx_idle = (p != 4);
      if (p == 2) begin
        tx_idle      = 1'b0;
        rx_long_hold = LONG_HOLD;
        repeat (BURST_ITEMS) offer_random();
        tx_idle = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) offer_random();
    end
    drain();

    if (fail_count == 0) begin
      $display("gamepad_event_generator_core_tb: PASS");
    end else begin
      $display("gamepad_event_generator_core_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/gpev_pkg.sv
rtl/core/gpev_lane.sv
rtl/core/gpev_merge.sv
rtl/core/gamepad_event_generator_core.sv
dv/gamepad_event_generator_core_checker.sv
dv/gamepad_event_generator_core_tb.sv
